### src/etsr_pkg.sv
// shared types and constants for the edge-timed 7e1 serial receiver
// no dependencies

package etsr_pkg;

    localparam int TIME_W        = 16;
    localparam int TICKS_PER_BIT = 4;
    localparam int IDLE_GAP_BITS = 9;
    localparam int GAP_TICKS     = IDLE_GAP_BITS * TICKS_PER_BIT;
    localparam int DATA_BITS     = 7;
    localparam int SLOT_W        = 4;
    localparam int CNT_W         = $clog2((GAP_TICKS + 1) / TICKS_PER_BIT + 1);
    localparam int IDX_W         = $clog2(DATA_BITS);

    localparam logic [SLOT_W-1:0] SLOT_START  = SLOT_W'(0);
    localparam logic [SLOT_W-1:0] SLOT_PARITY = SLOT_W'(DATA_BITS + 1);

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOTS,
        ST_FILL,
        ST_END
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic end_mark;
    } t_cmd;

    typedef struct packed {
        logic rx_active;
        logic in_gap;
        logic in_change;
        logic slots_zero;
        logic slot_zero;
        logic out_free;
    } t_status;

endpackage

### src/edge_timed_serial_receiver_7e1.sv
// edge-timed 7e1 serial receiver: one sample event in, 0 to 2 results out
// an event is accepted only while idle; an edge during a message then decodes the elapsed
// bit slots, and a gap fills the remaining slots of the character and then emits the end marker,
// one bit slot per cycle while the output register is free; output stalls hold the decoding
// synchronous active-low reset: line held high, receiver idle, no result pending
// depends on etsr_pkg, etsr_ctrl, etsr_datapath

module edge_timed_serial_receiver_7e1 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // tick_time[15:0], line_level[16], zero fill
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // data_char[6:0], parity_bad, framing_bad,
                                     // message_error, zero fill
    output logic        o_m_tuser    // kind
);

    etsr_pkg::t_cmd    cmd;
    etsr_pkg::t_status st;

    etsr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (i_s_tvalid),
        .o_in_tready (o_s_tready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    etsr_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_in_tdata   (i_s_tdata),
        .o_out_tvalid (o_m_tvalid),
        .i_out_tready (i_m_tready),
        .o_out_tdata  (o_m_tdata),
        .o_out_tuser  (o_m_tuser)
    );

`ifndef SYNTHESIS
    a_end_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == etsr_pkg::KIND_END) |-> (o_m_tdata[8:0] == 9'd0))
        else $error("end marker carries character bits or flags");

    a_step_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step || cmd.end_mark) |-> st.out_free)
        else $error("decode step while output register is occupied");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.step || cmd.finish || cmd.end_mark) |-> !o_s_tready)
        else $error("input accepted while an event is still in work");
`endif

endmodule

### src/etsr_ctrl.sv
// controller state machine: sequences slot decoding and result emission
// depends on etsr_pkg

module etsr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_tvalid,
    output logic              o_in_tready,
    input  etsr_pkg::t_status i_st,
    output etsr_pkg::t_cmd    o_cmd
);

    etsr_pkg::t_state r_state;
    etsr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= etsr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_tready = 1'b0;
        case (r_state)
            etsr_pkg::ST_IDLE: begin
                o_in_tready = 1'b1;
                if (i_in_tvalid) begin
                    o_cmd.load = 1'b1;
                    if (i_st.rx_active && i_st.in_gap) begin
                        n_state = etsr_pkg::ST_FILL;
                    end else if (i_st.rx_active && i_st.in_change) begin
                        n_state = etsr_pkg::ST_SLOTS;
                    end
                end
            end
            etsr_pkg::ST_SLOTS: begin
                if (i_st.slots_zero) begin
                    o_cmd.finish = 1'b1;
                    n_state      = etsr_pkg::ST_IDLE;
                end else if (i_st.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            etsr_pkg::ST_FILL: begin
                if (i_st.slot_zero) begin
                    n_state = etsr_pkg::ST_END;
                end else if (i_st.out_free) begin
                    o_cmd.step = 1'b1;
                end
            end
            etsr_pkg::ST_END: begin
                if (i_st.out_free) begin
                    o_cmd.end_mark = 1'b1;
                    n_state        = etsr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = etsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/etsr_datapath.sv
// datapath: edge timing, slot decoder, character registers, output register
// depends on etsr_pkg

module etsr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  etsr_pkg::t_cmd                      i_cmd,
    output etsr_pkg::t_status                   o_st,
    input  logic [etsr_pkg::IN_TDATA_W-1:0]     i_in_tdata,
    output logic                                o_out_tvalid,
    input  logic                                i_out_tready,
    output logic [etsr_pkg::OUT_TDATA_W-1:0]    o_out_tdata,
    output logic                                o_out_tuser
);

    logic                              r_held;
    logic [etsr_pkg::TIME_W-1:0]       r_last;
    logic                              r_receiving;
    logic [etsr_pkg::SLOT_W-1:0]       r_slot;
    logic [etsr_pkg::DATA_BITS-1:0]    r_bits;
    logic [1:0]                        r_flags;
    logic                              r_err;
    logic [etsr_pkg::CNT_W-1:0]        r_slots_left;
    logic [etsr_pkg::TIME_W-1:0]       r_now;
    logic                              r_lvl;
    logic                              r_out_valid;
    logic                              r_out_kind;
    logic [etsr_pkg::DATA_BITS-1:0]    r_out_char;
    logic                              r_out_par;
    logic                              r_out_frm;
    logic                              r_out_merr;

    logic                              n_held;
    logic [etsr_pkg::TIME_W-1:0]       n_last;
    logic                              n_receiving;
    logic [etsr_pkg::SLOT_W-1:0]       n_slot;
    logic [etsr_pkg::DATA_BITS-1:0]    n_bits;
    logic [1:0]                        n_flags;
    logic                              n_err;
    logic [etsr_pkg::CNT_W-1:0]        n_slots_left;
    logic                              n_out_valid;
    logic                              n_out_kind;
    logic [etsr_pkg::DATA_BITS-1:0]    n_out_char;
    logic                              n_out_par;
    logic                              n_out_frm;
    logic                              n_out_merr;

    logic [etsr_pkg::TIME_W-1:0]       in_now;
    logic                              in_lvl;
    logic [etsr_pkg::TIME_W-1:0]       elapsed;
    logic [etsr_pkg::TIME_W:0]         elapsed_p1;
    logic                              gap;
    logic [etsr_pkg::IDX_W-1:0]        bit_idx;
    logic [1:0]                        stop_flags;

    assign in_now     = i_in_tdata[etsr_pkg::TIME_W-1:0];
    assign in_lvl     = i_in_tdata[etsr_pkg::TIME_W];
    assign elapsed    = in_now - r_last;
    assign elapsed_p1 = {1'b0, elapsed} + (etsr_pkg::TIME_W+1)'(1);
    assign gap        = elapsed > etsr_pkg::TIME_W'(etsr_pkg::GAP_TICKS);
    assign bit_idx    = etsr_pkg::IDX_W'(r_slot - etsr_pkg::SLOT_W'(1));
    assign stop_flags = {r_flags[1] | ~r_held, r_flags[0]};

    assign o_st.rx_active  = r_receiving;
    assign o_st.in_gap     = gap;
    assign o_st.in_change  = in_lvl != r_held;
    assign o_st.slots_zero = r_slots_left == '0;
    assign o_st.slot_zero  = r_slot == etsr_pkg::SLOT_START;
    assign o_st.out_free   = !r_out_valid || i_out_tready;

    always_comb begin
        n_held       = r_held;
        n_last       = r_last;
        n_receiving  = r_receiving;
        n_slot       = r_slot;
        n_bits       = r_bits;
        n_flags      = r_flags;
        n_err        = r_err;
        n_slots_left = r_slots_left;
        n_out_valid  = r_out_valid && !i_out_tready;
        n_out_kind   = r_out_kind;
        n_out_char   = r_out_char;
        n_out_par    = r_out_par;
        n_out_frm    = r_out_frm;
        n_out_merr   = r_out_merr;

        if (i_cmd.load) begin
            n_slots_left = etsr_pkg::CNT_W'(elapsed_p1 / etsr_pkg::TICKS_PER_BIT);
            if (!r_receiving) begin
                if (r_held && !in_lvl) begin
                    n_receiving = 1'b1;
                    n_slot      = etsr_pkg::SLOT_START;
                    n_bits      = '0;
                    n_flags     = '0;
                    n_err       = 1'b0;
                end
                if (in_lvl != r_held) begin
                    n_held = in_lvl;
                    n_last = in_now;
                end
            end
        end

        if (i_cmd.step) begin
            n_slots_left = r_slots_left - etsr_pkg::CNT_W'(1);
            if (r_slot == etsr_pkg::SLOT_START) begin
                n_bits  = '0;
                n_flags = {r_held, 1'b0};
                n_slot  = r_slot + etsr_pkg::SLOT_W'(1);
            end else if (r_slot < etsr_pkg::SLOT_PARITY) begin
                n_bits[bit_idx] = r_held;
                n_slot          = r_slot + etsr_pkg::SLOT_W'(1);
            end else if (r_slot == etsr_pkg::SLOT_PARITY) begin
                n_flags[0] = r_flags[0] | (r_held != ^r_bits);
                n_slot     = r_slot + etsr_pkg::SLOT_W'(1);
            end else begin
                // stop bit: character done
                n_err       = r_err | (|stop_flags);
                n_out_valid = 1'b1;
                n_out_kind  = etsr_pkg::KIND_CHAR;
                n_out_char  = r_bits;
                n_out_par   = stop_flags[0];
                n_out_frm   = stop_flags[1];
                n_out_merr  = r_err | (|stop_flags);
                n_bits      = '0;
                n_flags     = '0;
                n_slot      = etsr_pkg::SLOT_START;
            end
        end

        if (i_cmd.finish || i_cmd.end_mark) begin
            n_held = r_lvl;
            n_last = r_now;
        end

        if (i_cmd.end_mark) begin
            n_out_valid = 1'b1;
            n_out_kind  = etsr_pkg::KIND_END;
            n_out_char  = '0;
            n_out_par   = 1'b0;
            n_out_frm   = 1'b0;
            n_out_merr  = r_err;
            n_receiving = 1'b0;
            n_slot      = etsr_pkg::SLOT_START;
            n_bits      = '0;
            n_flags     = '0;
            n_err       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= 1'b1;
            r_last       <= '0;
            r_receiving  <= 1'b0;
            r_slot       <= etsr_pkg::SLOT_START;
            r_bits       <= '0;
            r_flags      <= '0;
            r_err        <= 1'b0;
            r_slots_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_held       <= n_held;
            r_last       <= n_last;
            r_receiving  <= n_receiving;
            r_slot       <= n_slot;
            r_bits       <= n_bits;
            r_flags      <= n_flags;
            r_err        <= n_err;
            r_slots_left <= n_slots_left;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now <= in_now;
            r_lvl <= in_lvl;
        end
        r_out_kind <= n_out_kind;
        r_out_char <= n_out_char;
        r_out_par  <= n_out_par;
        r_out_frm  <= n_out_frm;
        r_out_merr <= n_out_merr;
    end

    assign o_out_tvalid = r_out_valid;
    assign o_out_tuser  = r_out_kind;
    assign o_out_tdata  = {(etsr_pkg::OUT_TDATA_W - etsr_pkg::DATA_BITS - 3)'(0),
                           r_out_merr, r_out_frm, r_out_par, r_out_char};

endmodule

### tb/sv/edge_timed_serial_receiver_7e1_tb.sv
// self-checking testbench for the edge-timed 7e1 serial receiver: line sample
// events in, decoded characters and end-of-message markers out
// depends on etsr_pkg and edge_timed_serial_receiver_7e1

module edge_timed_serial_receiver_7e1_tb;

    typedef struct {
        bit [15:0] tick;
        bit        level;
    } t_line_event;

    typedef struct {
        logic       kind;
        logic [6:0] data_char;
        logic       parity_bad;
        logic       framing_bad;
        logic       message_error;
    } t_rx_result;

    localparam int N_EVENTS      = 750;
    localparam int CALM_TAIL     = 100;
    localparam int HOLD_AT_CYCLE = 1000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    localparam bit [2:0] FLIP_NONE   = 3'b000;
    localparam bit [2:0] FLIP_PARITY = 3'b001;
    localparam bit [2:0] FLIP_START  = 3'b010;
    localparam bit [2:0] FLIP_STOP   = 3'b100;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata  = '0;   // tick_time[15:0], line_level[16], zero fill
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // data_char[6:0], parity_bad, framing_bad,
                                    // message_error, zero fill
    logic        o_m_tuser;         // kind

    t_line_event line_events[$];
    t_rx_result  expected_rx[$];
    int          events_total    = 0;
    int          events_accepted = 0;
    int          error_count     = 0;

    // sender and receiver pacing
    int send_gap   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    int cycle_no   = 0;

    // predicted receiver state
    bit        rx_level  = 1'b1;
    bit [15:0] rx_edge_t = '0;
    bit        rx_busy   = 1'b0;
    bit [3:0]  rx_slot   = '0;
    bit [6:0]  rx_bits   = '0;
    bit [1:0]  rx_flags  = '0;   // bit0 parity, bit1 framing
    bit        rx_err    = 1'b0;

    // line generator state
    int gen_t         = 0;
    int last_change_t = 0;
    bit gen_level     = 1'b1;
    bit noisy         = 1'b0;

    edge_timed_serial_receiver_7e1 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void decode_rx_slot(bit b);
        if (rx_slot == 0) begin
            rx_bits  = '0;
            rx_flags = '0;
            if (b) rx_flags[1] = 1'b1;
            rx_slot = 1;
        end else if (rx_slot <= 7) begin
            rx_bits[rx_slot - 1] = b;
            rx_slot++;
        end else if (rx_slot == 8) begin
            if (b != ^rx_bits) rx_flags[0] = 1'b1;
            rx_slot = 9;
        end else begin
            if (!b) rx_flags[1] = 1'b1;
            if (rx_flags != 0) rx_err = 1'b1;
            expected_rx.insert(expected_rx.size(), t_rx_result'{etsr_pkg::KIND_CHAR,
                               rx_bits, rx_flags[0], rx_flags[1], rx_err});
            rx_bits  = '0;
            rx_flags = '0;
            rx_slot  = 0;
        end
    endfunction

    function automatic void predict_rx_event(bit [15:0] tick, bit lvl);
        bit [15:0] elapsed;
        int        slots;
        elapsed = tick - rx_edge_t;
        if (!rx_busy) begin
            if (rx_level && !lvl) begin
                rx_busy  = 1'b1;
                rx_slot  = 0;
                rx_bits  = '0;
                rx_flags = '0;
                rx_err   = 1'b0;
            end
            if (lvl != rx_level) begin
                rx_level  = lvl;
                rx_edge_t = tick;
            end
            return;
        end
        if (lvl == rx_level && elapsed <= etsr_pkg::GAP_TICKS) return;
        if (elapsed > etsr_pkg::GAP_TICKS) begin
            while (rx_slot != 0) decode_rx_slot(rx_level);
            expected_rx.insert(expected_rx.size(),
                               t_rx_result'{etsr_pkg::KIND_END, 7'd0, 1'b0, 1'b0, rx_err});
            rx_busy  = 1'b0;
            rx_slot  = 0;
            rx_bits  = '0;
            rx_flags = '0;
            rx_err   = 1'b0;
        end else begin
            slots = (int'(elapsed) + 1) / etsr_pkg::TICKS_PER_BIT;
            for (int i = 0; i < slots; i++) decode_rx_slot(rx_level);
        end
        rx_level  = lvl;
        rx_edge_t = tick;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic push_event(int t, bit lvl);
        t_line_event ev;
        ev.tick  = 16'(t);
        ev.level = lvl;
        line_events.insert(line_events.size(), ev);
    endtask

    // pulse shorter than one bit slot right after the last edge
    task automatic glitch();
        push_event(last_change_t + 1, !gen_level);
        push_event(last_change_t + 2, gen_level);
        last_change_t += 2;
    endtask

    task automatic drive_slot(bit lvl);
        if (lvl != gen_level) begin
            last_change_t = gen_t + $urandom_range(0, 1);
            push_event(last_change_t, lvl);
            gen_level = lvl;
            if (noisy && $urandom_range(0, 39) == 0) glitch();
        end else if (noisy && $urandom_range(0, 9) == 0) begin
            push_event(gen_t + 2, lvl);
        end
        gen_t += etsr_pkg::TICKS_PER_BIT;
    endtask

    task automatic send_char(bit [6:0] data, bit [2:0] flips, int n_slots);
        bit [9:0] frame;
        frame[0]   = flips[1];
        frame[7:1] = data;
        frame[8]   = ^data ^ flips[0];
        frame[9]   = !flips[2];
        for (int i = 0; i < n_slots; i++) drive_slot(frame[i]);
    endtask

    task automatic open_message();
        if (!gen_level) begin
            gen_t += $urandom_range(1, 8);
            push_event(gen_t, 1'b1);
            last_change_t = gen_t;
            gen_level = 1'b1;
        end
        gen_t += $urandom_range(2, 20);
    endtask

    task automatic close_message();
        int t;
        t = last_change_t + etsr_pkg::GAP_TICKS + 1 + $urandom_range(0, 40);
        if (t < gen_t) t = gen_t;
        if (noisy && $urandom_range(0, 5) == 0) gen_level = !gen_level;
        push_event(t, gen_level);
        gen_t = t;
        last_change_t = t;
    endtask

    task automatic send_message(int n_chars, bit corrupt, bit truncate);
        bit [2:0] flips;
        if (noisy && $urandom_range(0, 7) == 0) gen_t = $urandom_range(0, 65535);
        open_message();
        for (int c = 0; c < n_chars; c++) begin
            flips = corrupt && $urandom_range(0, 2) == 0 ? 3'($urandom_range(1, 7)) : FLIP_NONE;
            if (c == 0) flips[1] = 1'b0;
            send_char(7'($urandom), flips, 10);
        end
        if (truncate) send_char(7'($urandom), FLIP_NONE, $urandom_range(1, 9));
        close_message();
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) gen_t = $urandom_range(0, 65535);
            else gen_t += $urandom_range(0, 12);
            gen_level = $urandom_range(0, 1);
            push_event(gen_t, gen_level);
        end
        // two spaced high samples bring the receiver back to idle
        for (int i = 0; i < 2; i++) begin
            gen_t += etsr_pkg::GAP_TICKS + 4;
            push_event(gen_t, 1'b1);
        end
        gen_level = 1'b1;
        last_change_t = gen_t;
    endtask

    always @(posedge i_clk) begin : sender
        t_line_event ev;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (send_gap > 0 || line_events.size() == 0) begin
                i_s_tvalid <= 1'b0;
                if (send_gap > 0) send_gap--;
            end else begin
                ev = line_events.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {7'd0, ev.level, ev.tick};
                if (line_events.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 4);
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            cycle_no++;
            if (cycle_no == HOLD_AT_CYCLE) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (line_events.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 3);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // results are checked before this edge's input transaction is predicted
    always @(posedge i_clk) begin : monitor
        t_rx_result got;
        t_rx_result want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tuser, o_m_tdata[6:0], o_m_tdata[7], o_m_tdata[8], o_m_tdata[9]};
                if (expected_rx.size() == 0) begin
                    $error("unexpected result: kind %0d data_char %0d", got.kind, got.data_char);
                    error_count++;
                end else begin
                    want = expected_rx.pop_front();
                    check_field("kind", want.kind, got.kind);
                    check_field("data_char", want.data_char, got.data_char);
                    check_field("parity_bad", want.parity_bad, got.parity_bad);
                    check_field("framing_bad", want.framing_bad, got.framing_bad);
                    check_field("message_error", want.message_error, got.message_error);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_rx_event(i_s_tdata[15:0], i_s_tdata[16]);
                events_accepted++;
            end
        end
    end

    initial begin
        int r;

        // directed
        push_event(4, 1'b1);
        gen_t = 8;
        send_char(7'h00, FLIP_NONE, 10);
        send_char(7'h7F, FLIP_NONE, 10);
        close_message();
        open_message();
        send_char(7'h55, FLIP_PARITY | FLIP_STOP, 10);
        close_message();
        open_message();
        send_char(7'h2A, FLIP_NONE, 10);
        send_char(7'h13, FLIP_START, 10);
        close_message();
        // partial character that ends with the line high, then a gap ends the message
        open_message();
        send_char(7'h04, FLIP_NONE, 4);
        close_message();
        open_message();
        // character complete before the gap: end marker alone
        send_char(7'h0F, FLIP_NONE, 10);
        drive_slot(1'b0);
        close_message();
        // gap boundary: 36 ticks held is no gap, 37 is
        open_message();
        send_char(7'h7F, FLIP_NONE, 2);
        push_event(last_change_t + etsr_pkg::GAP_TICKS, 1'b1);
        push_event(last_change_t + etsr_pkg::GAP_TICKS + 1, 1'b1);
        gen_t = last_change_t + etsr_pkg::GAP_TICKS + 1;
        last_change_t = gen_t;
        // tick counter wraps inside a character
        gen_t = 65528;
        open_message();
        drive_slot(1'b0);
        glitch();
        send_char(7'h5A, FLIP_NONE, 10);
        close_message();

        // random
        noisy = 1'b1;
        while (line_events.size() < N_EVENTS) begin
            r = $urandom_range(0, 19);
            if (r < 16) begin
                send_message($urandom_range(1, 5), $urandom_range(0, 3) == 0,
                             $urandom_range(0, 4) == 0);
            end else if (r < 19) begin
                send_noise($urandom_range(1, 6));
            end else begin
                gen_t += $urandom_range(1, 30);
                push_event(gen_t, gen_level);
            end
        end
        events_total = line_events.size();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (events_accepted < events_total || expected_rx.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
